[rtl/fpec_pkg.sv]
// Shared types, character constants and helper functions for the percent-escape codec.
package fpec_pkg;

	localparam logic [7:0] CH_PERCENT   = 8'h25;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_QUESTION  = 8'h3F;
	localparam logic [7:0] CH_LESS      = 8'h3C;
	localparam logic [7:0] CH_GREATER   = 8'h3E;
	localparam logic [7:0] CH_PIPE      = 8'h7C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CTRL_LIMIT   = 8'h20;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       bad;
		logic [1:0] cnt;
		logic       text_end;
	} fpec_cmd_t;

	typedef struct packed {
		logic valid;
		logic [3:0] value;
	} fpec_digit_t;

	function automatic logic needs_escape(input logic [7:0] c);
		needs_escape = (c < CTRL_LIMIT) || (c == CH_STAR) || (c == CH_QUESTION) ||
			(c == CH_LESS) || (c == CH_GREATER) || (c == CH_PIPE) || (c == CH_QUOTE) ||
			(c == CH_COLON) || (c == CH_SLASH) || (c == CH_BACKSLASH);
	endfunction

	function automatic logic [7:0] hex_lower(input logic [3:0] v);
		if (v < 4'd10) begin
			hex_lower = 8'h30 + {4'd0, v};
		end else begin
			hex_lower = 8'h57 + {4'd0, v};
		end
	endfunction

	function automatic fpec_digit_t hex_value(input logic [7:0] c);
		fpec_digit_t r;
		r.valid = 1'b1;
		r.value = c[3:0];
		if (c >= 8'h30 && c <= 8'h39) begin
			r.value = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.value = c[3:0] + 4'd9;
		end else begin
			r.valid = 1'b0;
		end
		hex_value = r;
	endfunction

endpackage

[rtl/fpec_feed_if.sv]
// Input stream channel: one text byte and its end-of-text mark per transaction.
interface fpec_feed_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_end;

	modport source (output valid, in_byte, text_end, input ready);
	modport sink (input valid, in_byte, text_end, output ready);
endinterface

[rtl/fpec_result_if.sv]
// Output stream channel: one produced byte and its flags per transaction.
interface fpec_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       bad_escape;
	logic       run_last;
	logic       text_done;

	modport source (output valid, out_byte, bad_escape, run_last, text_done, input ready);
	modport sink (input valid, out_byte, bad_escape, run_last, text_done, output ready);
endinterface

[rtl/filename_percent_escape_codec.sv]
// Filename percent-escape codec top level: config register, front end, queue, sequencer.
// The first result of an input byte passes through the command queue and then the output register.
// Throughput: one result per cycle while result.ready is held; a byte yields zero to three results
//   (three when escaped in encode), drained from the command queue by the single output register.
// Input is accepted every cycle while the command queue has room.
// Reset clears direction to encode, the escape state, the queue and the output valid.
module filename_percent_escape_codec
	import fpec_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	fpec_feed_if.sink     feed,
	fpec_result_if.source result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	logic      direction_q;
	logic      cfg_wr;
	logic      push;
	logic      pop;
	logic      full;
	logic      empty;
	fpec_cmd_t push_cmd;
	fpec_cmd_t head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {31'd0, direction_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
		end else if (cfg_wr) begin
			direction_q <= pwdata[0];
		end
	end

	fpec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed),
		.direction (direction_q),
		.cfg_clear (cfg_wr),
		.full      (full),
		.push      (push),
		.cmd       (push_cmd)
	);

	fpec_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	fpec_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bad_escape |-> result.out_byte == 8'd0)
		else $error("error result carries a nonzero byte");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.text_done |-> result.run_last)
		else $error("text end flagged on a result that is not the last of its byte");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result.valid && result.run_last)
		else $error("command retired without its last result");
`endif

endmodule

[rtl/fpec_front.sv]
// Front end: accepts text bytes, tracks the escape state and builds output commands.
module fpec_front
	import fpec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fpec_feed_if.sink   feed,
	input  logic        direction,
	input  logic        cfg_clear,
	input  logic        full,
	output logic        push,
	output fpec_cmd_t   cmd
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	logic [1:0]  phase_q;
	logic [3:0]  held_q;
	logic [1:0]  phase_nxt;
	logic [3:0]  held_nxt;
	logic        accept;
	logic [7:0]  c;
	fpec_digit_t d;

	assign feed.ready = !full;
	assign accept     = feed.valid && feed.ready;
	assign c          = feed.in_byte;
	assign d          = hex_value(c);
	assign push       = accept && (cmd.cnt != 2'd0);

	always_comb begin
		cmd          = '0;
		cmd.text_end = feed.text_end;
		phase_nxt    = PH_IDLE;
		held_nxt     = held_q;
		if (direction == DIR_ENCODE) begin
			if (needs_escape(c)) begin
				cmd.cnt = 2'd3;
				cmd.b0  = CH_PERCENT;
				cmd.b1  = hex_lower(c[7:4]);
				cmd.b2  = hex_lower(c[3:0]);
			end else if (c == CH_PERCENT) begin
				cmd.cnt = 2'd2;
				cmd.b0  = CH_PERCENT;
				cmd.b1  = CH_PERCENT;
			end else begin
				cmd.cnt = 2'd1;
				cmd.b0  = c;
			end
		end else begin
			case (phase_q)
				PH_PCT: begin
					if (c == CH_PERCENT) begin
						cmd.cnt = 2'd1;
						cmd.b0  = CH_PERCENT;
					end else if (d.valid) begin
						if (feed.text_end) begin
							cmd.cnt = 2'd1;
							cmd.b0  = {4'd0, d.value};
						end else begin
							held_nxt  = d.value;
							phase_nxt = PH_DIGIT;
						end
					end else begin
						cmd.cnt = (c == CH_NEWLINE) ? 2'd2 : 2'd1;
						cmd.bad = 1'b1;
						cmd.b1  = c;
					end
				end
				PH_DIGIT: begin
					if (d.valid) begin
						cmd.cnt = 2'd1;
						cmd.b0  = {held_q, d.value};
					end else begin
						cmd.cnt = (c == CH_NEWLINE) ? 2'd2 : 2'd1;
						cmd.b0  = {4'd0, held_q};
						cmd.b1  = c;
					end
				end
				default: begin
					if (c == CH_PERCENT) begin
						if (feed.text_end) begin
							cmd.cnt = 2'd1;
							cmd.bad = 1'b1;
						end else begin
							phase_nxt = PH_PCT;
						end
					end else begin
						cmd.cnt = 2'd1;
						cmd.b0  = c;
					end
				end
			endcase
		end
		if (feed.text_end) begin
			phase_nxt = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= 4'd0;
		end else if (cfg_clear) begin
			phase_q <= PH_IDLE;
			held_q  <= 4'd0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			held_q  <= held_nxt;
		end
	end

endmodule

[rtl/fpec_fifo.sv]
// Short command queue between the front end and the output sequencer.
module fpec_fifo
	import fpec_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  fpec_cmd_t push_cmd,
	input  logic      pop,
	output fpec_cmd_t head,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fpec_cmd_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/fpec_back.sv]
// Output sequencer: walks the bytes of each queued command into the output register.
module fpec_back
	import fpec_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  fpec_cmd_t     head,
	input  logic          empty,
	output logic          pop,
	fpec_result_if.source result
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       bad_q;
	logic       last_q;
	logic       done_q;
	logic       advance;
	logic       take;
	logic       is_last;
	logic [7:0] pick;

	assign advance = !valid_q || result.ready;
	assign take    = advance && !empty;
	assign is_last = (idx_q == head.cnt - 2'd1);
	assign pop     = take && is_last;

	always_comb begin
		case (idx_q)
			2'd0:    pick = head.b0;
			2'd1:    pick = head.b1;
			default: pick = head.b2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= !empty;
			end
			if (take) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bad_q  <= head.bad && (idx_q == 2'd0);
			byte_q <= (head.bad && (idx_q == 2'd0)) ? 8'd0 : pick;
			last_q <= is_last;
			done_q <= is_last && head.text_end;
		end
	end

	assign result.valid      = valid_q;
	assign result.out_byte   = byte_q;
	assign result.bad_escape = bad_q;
	assign result.run_last   = last_q;
	assign result.text_done  = done_q;

endmodule

[dv/fpec_tb_pkg.sv]
// Register map shared by the codec testbench stimulus and checker.
`timescale 1ns / 100ps
package fpec_tb_pkg;

	localparam logic [2:0] ADDR_DIRECTION = 3'd0;

endpackage

[dv/fpec_codec_checker.sv]
// Checker for the percent-escape codec: predicts escaped or unescaped bytes and compares results.
`timescale 1ns / 100ps
module fpec_codec_checker
	import fpec_pkg::*;
	import fpec_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fpec_feed_if        feed,
	fpec_result_if      result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          pending_results
);

	typedef enum logic [1:0] {
		ESC_IDLE,
		ESC_PERCENT,
		ESC_DIGIT
	} esc_phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       bad_escape;
		logic       run_last;
		logic       text_done;
	} codec_result_t;

	codec_result_t expected_bytes[$];
	logic          direction_q;
	esc_phase_t    phase_q;
	logic [3:0]    held_q;

	function automatic logic escaped_char(input logic [7:0] c);
		case (c)
			CH_STAR, CH_QUESTION, CH_LESS, CH_GREATER, CH_PIPE,
			CH_QUOTE, CH_COLON, CH_SLASH, CH_BACKSLASH: return 1'b1;
			default: return c < CTRL_LIMIT;
		endcase
	endfunction

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + {4'd0, n};
		end
		return 8'h61 + {4'd0, n} - 8'd10;
	endfunction

	// {valid, value}
	function automatic logic [4:0] digit_value(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= "0" && c <= "9") begin
			v = c - "0";
		end else if (c >= "a" && c <= "f") begin
			v = c - "a" + 8'd10;
		end else if (c >= "A" && c <= "F") begin
			v = c - "A" + 8'd10;
		end else begin
			return 5'd0;
		end
		return {1'b1, v[3:0]};
	endfunction

	task automatic push_result(input logic [7:0] b, input logic bad);
		codec_result_t r;
		r.out_byte   = bad ? 8'h00 : b;
		r.bad_escape = bad;
		r.run_last   = 1'b0;
		r.text_done  = 1'b0;
		expected_bytes.push_back(r);
	endtask

	task automatic predict_codec_output(input logic [7:0] c, input logic last);
		logic [4:0]    dig;
		codec_result_t tail;
		int            prior_size;
		prior_size = expected_bytes.size();
		dig = digit_value(c);
		if (direction_q == DIR_ENCODE) begin
			if (escaped_char(c)) begin
				push_result(CH_PERCENT, 1'b0);
				push_result(nibble_char(c[7:4]), 1'b0);
				push_result(nibble_char(c[3:0]), 1'b0);
			end else if (c == CH_PERCENT) begin
				push_result(CH_PERCENT, 1'b0);
				push_result(CH_PERCENT, 1'b0);
			end else begin
				push_result(c, 1'b0);
			end
			phase_q = ESC_IDLE;
		end else begin
			case (phase_q)
				ESC_PERCENT: begin
					phase_q = ESC_IDLE;
					if (c == CH_PERCENT) begin
						push_result(CH_PERCENT, 1'b0);
					end else if (dig[4]) begin
						if (last) begin
							push_result({4'h0, dig[3:0]}, 1'b0);
						end else begin
							held_q  = dig[3:0];
							phase_q = ESC_DIGIT;
						end
					end else begin
						push_result(8'h00, 1'b1);
						if (c == CH_NEWLINE) begin
							push_result(c, 1'b0);
						end
					end
				end
				ESC_DIGIT: begin
					if (dig[4]) begin
						push_result({held_q, dig[3:0]}, 1'b0);
					end else begin
						push_result({4'h0, held_q}, 1'b0);
						if (c == CH_NEWLINE) begin
							push_result(c, 1'b0);
						end
					end
					phase_q = ESC_IDLE;
				end
				default: begin
					if (c == CH_PERCENT) begin
						if (last) begin
							push_result(8'h00, 1'b1);
						end else begin
							phase_q = ESC_PERCENT;
						end
					end else begin
						push_result(c, 1'b0);
					end
				end
			endcase
		end
		if (last) begin
			phase_q = ESC_IDLE;
		end
		if (expected_bytes.size() > prior_size) begin
			tail = expected_bytes.pop_back();
			tail.run_last  = 1'b1;
			tail.text_done = last;
			expected_bytes.push_back(tail);
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_result;
		codec_result_t want;
		if (expected_bytes.size() == 0) begin
			mismatch_count++;
			$display("%0t: unexpected transaction, expected none actual %0h", $time,
				result.out_byte);
		end else begin
			want = expected_bytes.pop_front();
			compare_field("out_byte", want.out_byte, result.out_byte);
			compare_field("bad_escape", want.bad_escape, result.bad_escape);
			compare_field("run_last", want.run_last, result.run_last);
			compare_field("text_done", want.text_done, result.text_done);
		end
	endtask

	initial begin
		mismatch_count  = 0;
		pending_results = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q = DIR_ENCODE;
			phase_q     = ESC_IDLE;
			held_q      = 4'h0;
			expected_bytes.delete();
		end else begin
			if (result.valid && result.ready) begin
				check_result();
			end
			if (feed.valid && feed.ready) begin
				predict_codec_output(feed.in_byte, feed.text_end);
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_DIRECTION) begin
				direction_q = pwdata[0];
				phase_q     = ESC_IDLE;
				held_q      = 4'h0;
			end
		end
		pending_results = expected_bytes.size();
	end

endmodule

[dv/tb_filename_percent_escape_codec.sv]
// Testbench top for the percent-escape codec: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_filename_percent_escape_codec;
	import fpec_pkg::*;
	import fpec_tb_pkg::*;

	localparam int IDLE_LIMIT    = 1000;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 8;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic feed_idle;
	logic drain_idle;
	logic hold_request;
	logic hold_served;
	int   mismatch_count;
	int   pending_results;
	int   idle_cycles = 0;

	logic [7:0] enc_directed [13] = '{8'h00, 8'h1F, CTRL_LIMIT, CH_STAR, CH_QUESTION,
		CH_LESS, CH_GREATER, CH_PIPE, CH_QUOTE, CH_COLON, CH_SLASH, CH_BACKSLASH,
		CH_PERCENT};

	// {text_end, byte}
	logic [8:0] dec_directed [20] = '{
		{1'b0, CH_PERCENT}, {1'b0, CH_PERCENT},
		{1'b0, CH_PERCENT}, {1'b0, 8'h34}, {1'b0, 8'h41},
		{1'b0, CH_PERCENT}, {1'b0, 8'h67},
		{1'b0, CH_PERCENT}, {1'b0, CH_NEWLINE},
		{1'b0, CH_PERCENT}, {1'b0, 8'h37}, {1'b0, 8'h7A},
		{1'b0, CH_PERCENT}, {1'b0, 8'h62}, {1'b0, CH_NEWLINE},
		{1'b0, CH_PERCENT}, {1'b1, 8'h63},
		{1'b1, CH_PERCENT},
		{1'b0, CH_PERCENT}, {1'b0, 8'h35}
	};

	fpec_feed_if   feed_ch ();
	fpec_result_if result_ch ();

	filename_percent_escape_codec u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.feed    (feed_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	fpec_codec_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.feed            (feed_ch),
		.result          (result_ch),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] random_hex_char;
		int v;
		v = $urandom_range(21);
		if (v < 10) begin
			return 8'h30 + v[7:0];
		end else if (v < 16) begin
			return 8'h61 + v[7:0] - 8'd10;
		end
		return 8'h41 + v[7:0] - 8'd16;
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic last);
		@(negedge clk);
		while (feed_idle && $urandom_range(99) < 30) begin
			feed_ch.valid = 1'b0;
			@(negedge clk);
		end
		feed_ch.valid    = 1'b1;
		feed_ch.in_byte  = c;
		feed_ch.text_end = last;
		@(posedge clk);
		while (!feed_ch.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic settle;
		@(negedge clk);
		feed_ch.valid = 1'b0;
		while (pending_results != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_direction(input logic value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_DIRECTION;
		pwdata  = {31'd0, value};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic encode_run(input int count);
		logic [7:0] c;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0) begin
				c = enc_directed[$urandom_range(12)];
			end else begin
				c = 8'($urandom_range(255));
			end
			send_byte(c, $urandom_range(9) == 0);
		end
	endtask

	task automatic decode_run(input int count);
		int   sent;
		int   pick;
		logic last;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			last = $urandom_range(7) == 0;
			if (pick < 50) begin
				send_byte(CH_PERCENT, 1'b0);
				send_byte(random_hex_char(), 1'b0);
				send_byte(random_hex_char(), last);
				sent += 3;
			end else if (pick < 60) begin
				send_byte(CH_PERCENT, 1'b0);
				send_byte(CH_PERCENT, last);
				sent += 2;
			end else if (pick < 85) begin
				send_byte(8'($urandom_range(255)), last);
				sent += 1;
			end else if (pick < 93) begin
				send_byte(CH_PERCENT, 1'b0);
				send_byte($urandom_range(1) ? CH_NEWLINE : 8'($urandom_range(255)), last);
				sent += 2;
			end else begin
				send_byte(CH_PERCENT, 1'b0);
				send_byte(random_hex_char(), 1'b0);
				send_byte($urandom_range(1) ? CH_NEWLINE : 8'($urandom_range(255)), last);
				sent += 3;
			end
		end
	endtask

	initial begin
		result_ch.ready = 1'b0;
		hold_served     = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_served) begin
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_served = 1'b1;
			end
			result_ch.ready = !(drain_idle && $urandom_range(99) < 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((feed_ch.valid && feed_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(psel && penable && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		feed_ch.valid    = 1'b0;
		feed_ch.in_byte  = 8'h00;
		feed_ch.text_end = 1'b0;
		feed_idle        = 1'b1;
		drain_idle       = 1'b1;
		hold_request     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		write_direction(DIR_ENCODE);
		foreach (enc_directed[i]) begin
			send_byte(enc_directed[i], 1'b0);
		end
		send_byte(8'hFF, 1'b1);
		settle();

		write_direction(DIR_DECODE);
		foreach (dec_directed[i]) begin
			send_byte(dec_directed[i][7:0], dec_directed[i][8]);
		end
		settle();

		// drops the escape left open above
		write_direction(DIR_DECODE);
		hold_request = 1'b1;
		decode_run(40);
		settle();

		feed_idle  = 1'b0;
		drain_idle = 1'b0;
		write_direction(DIR_ENCODE);
		encode_run(30);
		settle();
		feed_idle  = 1'b1;
		drain_idle = 1'b1;

		write_direction(DIR_DECODE);
		decode_run(40);
		settle();

		write_direction(DIR_ENCODE);
		encode_run(16);
		settle();

		if (mismatch_count == 0 && pending_results == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[files.f]
rtl/fpec_pkg.sv
rtl/fpec_feed_if.sv
rtl/fpec_result_if.sv
rtl/fpec_front.sv
rtl/fpec_fifo.sv
rtl/fpec_back.sv
rtl/filename_percent_escape_codec.sv
dv/fpec_tb_pkg.sv
dv/fpec_codec_checker.sv
dv/tb_filename_percent_escape_codec.sv
